/* design/gbp_pkg.sv */
// shared types, constants and codes of the global history branch predictor
`timescale 1ns / 1ps

package gbp_pkg;

	// default sizes, handed to the top level parameters
	localparam int BTB_ENTRIES_DEF  = 128;
	localparam int HISTORY_BITS_DEF = 8;

	// fixed field widths
	localparam int ADDR_W  = 32;
	localparam int STAT_W  = 32;
	localparam int CTR_W   = 2;
	localparam int VERD_W  = 2;

	// verdict codes
	localparam logic [VERD_W-1:0] VERDICT_NONE    = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_CORRECT = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_MISPRED = 2'd2;

	// pattern counter values
	localparam logic [CTR_W-1:0] CTR_SEED_TAKEN = 2'd2;
	localparam logic [CTR_W-1:0] CTR_SEED_NOT   = 2'd1;
	localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
	localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;

	// distance from a branch to the next instruction
	localparam logic [ADDR_W-1:0] PC_STEP = 32'd4;

	// search token that walks the buffer cells
	typedef struct packed {
		logic              vld;
		logic [ADDR_W-1:0] baddr;
		logic              hit;
		logic [ADDR_W-1:0] tgt;
	} query_t;

	// buffer write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] baddr;
		logic [ADDR_W-1:0] tgt;
	} btb_wr_t;

endpackage

/* design/gbp_req_if.sv */
// branch resolution request channel
`timescale 1ns / 1ps

interface gbp_req_if;
	logic                      valid;
	logic                      ready;
	logic                      is_cond_branch;
	logic                      resolved;
	logic [gbp_pkg::ADDR_W-1:0] pc_plus_four;
	logic [gbp_pkg::ADDR_W-1:0] target_addr;
	logic                      taken;

	modport source (
		output valid, is_cond_branch, resolved, pc_plus_four, target_addr, taken,
		input  ready
	);
	modport sink (
		input  valid, is_cond_branch, resolved, pc_plus_four, target_addr, taken,
		output ready
	);
endinterface

/* design/gbp_rsp_if.sv */
// prediction result channel
`timescale 1ns / 1ps

interface gbp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       redirect;
	logic [gbp_pkg::ADDR_W-1:0] redirect_pc;
	logic                       btb_hit;
	logic [gbp_pkg::VERD_W-1:0] verdict;
	logic [gbp_pkg::STAT_W-1:0] success_total;
	logic [gbp_pkg::STAT_W-1:0] fail_total;
	logic [gbp_pkg::STAT_W-1:0] not_taken_total;

	modport source (
		output valid, redirect, redirect_pc, btb_hit, verdict,
		output success_total, fail_total, not_taken_total,
		input  ready
	);
	modport sink (
		input  valid, redirect, redirect_pc, btb_hit, verdict,
		input  success_total, fail_total, not_taken_total,
		output ready
	);
endinterface

/* design/gbp_cell.sv */
// one target buffer entry that compares the passing search token
`timescale 1ns / 1ps

module gbp_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 8,
	parameter int IDX_W    = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gbp_pkg::query_t      qin,
	output gbp_pkg::query_t      qout,
	input  logic [CNT_W-1:0]     count,
	input  gbp_pkg::btb_wr_t     wr,
	input  logic [IDX_W-1:0]     wr_idx
);

	logic [gbp_pkg::ADDR_W-1:0] entry_baddr_q;
	logic [gbp_pkg::ADDR_W-1:0] entry_tgt_q;
	gbp_pkg::query_t            tok_q;
	logic                       live;
	logic                       match;

	// entry storage, written by the broadcast when addressed
	always_ff @(posedge clk) begin
		if (wr.en && (wr_idx == IDX_W'(CELL_IDX))) begin
			entry_baddr_q <= wr.baddr;
			entry_tgt_q   <= wr.tgt;
		end
	end

	// only filled entries take part, the first match wins
	always_comb begin
		live  = (count > CNT_W'(CELL_IDX));
		match = qin.vld && !qin.hit && live && (entry_baddr_q == qin.baddr);
	end

	// hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld   <= qin.vld;
			tok_q.baddr <= qin.baddr;
			tok_q.hit   <= qin.hit | match;
			tok_q.tgt   <= match ? entry_tgt_q : qin.tgt;
		end
	end

	assign qout = tok_q;

endmodule

/* design/gbp_chain.sv */
// row of target buffer cells that the search token walks one per cycle
`timescale 1ns / 1ps

module gbp_chain #(
	parameter int ENTRIES = 128,
	parameter int CNT_W   = 8,
	parameter int IDX_W   = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gbp_pkg::query_t  head,
	output gbp_pkg::query_t  tail,
	input  logic [CNT_W-1:0] count,
	input  gbp_pkg::btb_wr_t wr,
	input  logic [IDX_W-1:0] wr_idx
);

	gbp_pkg::query_t links [ENTRIES+1];

	assign links[0] = head;

	// one cell per entry, each feeding its neighbor
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		gbp_cell #(
			.CELL_IDX (g),
			.CNT_W    (CNT_W),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.qin    (links[g]),
			.qout   (links[g+1]),
			.count  (count),
			.wr     (wr),
			.wr_idx (wr_idx)
		);
	end

	assign tail = links[ENTRIES];

endmodule

/* design/global_history_branch_predictor_top.sv */
// global history branch predictor with a branch target buffer
`timescale 1ns / 1ps

// Takes one branch resolution beat on req and returns one result beat on rsp.
// A conditional branch walks a row of BTB_ENTRIES target buffer cells, one
// cell per cycle, then commits: insert on a miss if there is room, update
// the 2-bit counter picked by the global history on a resolved hit, count
// the statistics and raise redirect on a taken miss or a misprediction.
// A conditional branch passes the cell row and then waits in the done state
// for its commit; any other item goes to the done state at once. The result
// is registered at the commit. req is ready again only after the commit, so
// a new item is taken only once the last one is through.
// The result sits in an output register: req takes the next beat while a
// result waits. If rsp stays stalled, the next item waits before its commit
// until the register is free, and req stays low meanwhile.
// Reset empties the target buffer and clears the history and statistics,
// then a clearing pass zeroes all 2^HISTORY_BITS pattern counters; req
// stays low during the pass.

module global_history_branch_predictor_top #(
	parameter int BTB_ENTRIES  = gbp_pkg::BTB_ENTRIES_DEF,
	parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gbp_req_if.sink   req,
	gbp_rsp_if.source rsp
);

	localparam int CNT_W   = $clog2(BTB_ENTRIES + 1);
	localparam int IDX_W   = $clog2(BTB_ENTRIES);
	localparam int PHT_N   = 1 << HISTORY_BITS;
	localparam int ADDR_W  = gbp_pkg::ADDR_W;
	localparam int STAT_W  = gbp_pkg::STAT_W;
	localparam int CTR_W   = gbp_pkg::CTR_W;
	localparam int VERD_W  = gbp_pkg::VERD_W;

	// sequencer states
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]              state_q;
	logic [HISTORY_BITS-1:0] clr_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic [CNT_W-1:0]        count_q;
	logic [STAT_W-1:0]       succ_q;
	logic [STAT_W-1:0]       fail_q;
	logic [STAT_W-1:0]       nt_q;

	// item held while it is searched
	logic                    is_cb_q;
	logic                    resolved_q;
	logic                    taken_q;
	logic [ADDR_W-1:0]       pc4_q;
	logic [ADDR_W-1:0]       tgt_q;
	logic                    hit_q;
	logic [ADDR_W-1:0]       etgt_q;

	// pattern counter memory
	logic [CTR_W-1:0]        pht_mem [PHT_N];
	logic [CTR_W-1:0]        pht_rd_q;
	logic                    pht_we;
	logic [HISTORY_BITS-1:0] pht_waddr;
	logic [CTR_W-1:0]        pht_wdata;

	// result register
	logic                    out_vld_q;
	logic                    redirect_q;
	logic [ADDR_W-1:0]       rpc_q;
	logic                    btb_hit_q;
	logic [VERD_W-1:0]       verdict_q;

	gbp_pkg::query_t         head;
	gbp_pkg::query_t         tail;
	gbp_pkg::btb_wr_t        btb_wr;

	logic                    accept;
	logic                    commit;
	logic                    upd_we;
	logic [CTR_W-1:0]        upd_ctr;
	logic                    n_redirect;
	logic [ADDR_W-1:0]       n_rpc;
	logic [VERD_W-1:0]       n_verdict;
	logic [STAT_W-1:0]       n_succ;
	logic [STAT_W-1:0]       n_fail;
	logic [STAT_W-1:0]       n_nt;
	logic                    n_insert;
	logic                    pred_taken;

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	// search token enters the first cell on the request beat
	always_comb begin
		head       = '0;
		head.vld   = accept && req.is_cond_branch;
		head.baddr = req.pc_plus_four - gbp_pkg::PC_STEP;
	end

	gbp_chain #(
		.ENTRIES (BTB_ENTRIES),
		.CNT_W   (CNT_W),
		.IDX_W   (IDX_W)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.tail   (tail),
		.count  (count_q),
		.wr     (btb_wr),
		.wr_idx (count_q[IDX_W-1:0])
	);

	// commit decision for the held item
	always_comb begin
		pred_taken = (pht_rd_q >= gbp_pkg::CTR_SEED_TAKEN);
		upd_we     = 1'b0;
		upd_ctr    = pht_rd_q;
		n_redirect = 1'b0;
		n_rpc      = '0;
		n_verdict  = gbp_pkg::VERDICT_NONE;
		n_succ     = succ_q;
		n_fail     = fail_q;
		n_nt       = nt_q;
		n_insert   = 1'b0;
		if (is_cb_q) begin
			if (!hit_q) begin
				// miss: insert if room, seed the counter
				n_insert = (count_q < CNT_W'(BTB_ENTRIES));
				upd_we   = 1'b1;
				if (taken_q) begin
					upd_ctr    = gbp_pkg::CTR_SEED_TAKEN;
					n_redirect = 1'b1;
					n_rpc      = tgt_q;
				end else begin
					upd_ctr = gbp_pkg::CTR_SEED_NOT;
				end
			end else if (resolved_q) begin
				upd_we = 1'b1;
				if (taken_q) begin
					if (pht_rd_q != gbp_pkg::CTR_MAX) begin
						upd_ctr = pht_rd_q + CTR_W'(1);
					end
					if (pred_taken) begin
						n_succ    = succ_q + STAT_W'(1);
						n_verdict = gbp_pkg::VERDICT_CORRECT;
					end else begin
						n_fail     = fail_q + STAT_W'(1);
						n_verdict  = gbp_pkg::VERDICT_MISPRED;
						n_redirect = 1'b1;
						n_rpc      = etgt_q;
					end
				end else begin
					if (pht_rd_q != gbp_pkg::CTR_MIN) begin
						upd_ctr = pht_rd_q - CTR_W'(1);
					end
					n_nt = nt_q + STAT_W'(1);
					if (!pred_taken) begin
						n_succ    = succ_q + STAT_W'(1);
						n_verdict = gbp_pkg::VERDICT_CORRECT;
					end else begin
						n_fail     = fail_q + STAT_W'(1);
						n_verdict  = gbp_pkg::VERDICT_MISPRED;
						n_redirect = 1'b1;
						n_rpc      = pc4_q;
					end
				end
			end
		end
	end

	// buffer insert broadcast
	always_comb begin
		btb_wr.en    = commit && n_insert;
		btb_wr.baddr = pc4_q - gbp_pkg::PC_STEP;
		btb_wr.tgt   = tgt_q;
	end

	// single write port: clearing pass or counter update
	always_comb begin
		if (state_q == ST_CLEAR) begin
			pht_we    = 1'b1;
			pht_waddr = clr_q;
			pht_wdata = gbp_pkg::CTR_MIN;
		end else begin
			pht_we    = commit && upd_we;
			pht_waddr = hist_q;
			pht_wdata = upd_ctr;
		end
	end

	always_ff @(posedge clk) begin
		if (pht_we) begin
			pht_mem[pht_waddr] <= pht_wdata;
		end
		pht_rd_q <= pht_mem[hist_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + HISTORY_BITS'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= req.is_cond_branch ? ST_WALK : ST_DONE;
					end
				end
				ST_WALK: begin
					if (tail.vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// held item and search outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			is_cb_q    <= req.is_cond_branch;
			resolved_q <= req.resolved;
			taken_q    <= req.taken;
			pc4_q      <= req.pc_plus_four;
			tgt_q      <= req.target_addr;
			hit_q      <= 1'b0;
		end else if ((state_q == ST_WALK) && tail.vld) begin
			hit_q  <= tail.hit;
			etgt_q <= tail.tgt;
		end
	end

	// architectural state updated at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			count_q <= '0;
			succ_q  <= '0;
			fail_q  <= '0;
			nt_q    <= '0;
		end else if (commit) begin
			if (resolved_q) begin
				hist_q <= {hist_q[HISTORY_BITS-2:0], taken_q};
			end
			if (n_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			succ_q <= n_succ;
			fail_q <= n_fail;
			nt_q   <= n_nt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (commit) begin
			redirect_q <= n_redirect;
			rpc_q      <= n_rpc;
			btb_hit_q  <= is_cb_q && hit_q;
			verdict_q  <= n_verdict;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.redirect        = redirect_q;
	assign rsp.redirect_pc     = rpc_q;
	assign rsp.btb_hit         = btb_hit_q;
	assign rsp.verdict         = verdict_q;
	assign rsp.success_total   = succ_q;
	assign rsp.fail_total      = fail_q;
	assign rsp.not_taken_total = nt_q;

endmodule

/* design/gbp_checker.sv */
// port level checks of the branch predictor, bound to the top level
`timescale 1ns / 1ps

module gbp_checker (
	input logic       clk,
	input logic       arst_n,
	gbp_req_if.sink   req,
	gbp_rsp_if.source rsp
);

	// a waiting result beat holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.redirect_pc)
			&& $stable(rsp.verdict))
		else $error("result beat changed while stalled");

	// one item at a time: no request beat right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an item is in flight");

	// a misprediction always redirects fetch
	a_mispred_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.verdict == gbp_pkg::VERDICT_MISPRED) |-> rsp.redirect)
		else $error("misprediction without redirect");

	// a verdict only comes from a buffer hit
	a_verdict_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.verdict != gbp_pkg::VERDICT_NONE) |-> rsp.btb_hit)
		else $error("verdict without a buffer hit");

endmodule

bind global_history_branch_predictor_top gbp_checker u_gbp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
